// ===== sv/ffvt_pkg.sv =====
// Shared types and constants of the fern vote/train engine.
`timescale 1ns / 1ps
package ffvt_pkg;

  localparam int CodeW    = 13;
  localparam int InFerns  = 10;
  localparam int VoteW    = 20;
  localparam int PostW    = 17;
  localparam int ReqW     = 2;

  localparam logic [ReqW-1:0] REQ_CLASSIFY = 2'd0;
  localparam logic [ReqW-1:0] REQ_TRAIN_POS = 2'd1;
  localparam logic [ReqW-1:0] REQ_TRAIN_NEG = 2'd2;

  localparam logic [0:0] REG_FERNS_USED = 1'b0;
  localparam logic [0:0] REG_POS_THRESH = 1'b1;

  localparam logic [3:0]  FernsUsedReset = 4'd10;
  localparam logic [15:0] PosThreshReset = 16'd39322;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_TRAIN,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Commands from the sequencer to every lane.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic div_start;
    logic positive;
    logic clear_en;
  } lane_ctl_t;

endpackage

// ===== sv/ffvt_div.sv =====
// Restoring divider, one quotient bit per cycle: (p << 16) / t.
`timescale 1ns / 1ps
module ffvt_div #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] pos,
  input  logic [COUNT_BITS:0]   total,
  output logic                  busy,
  output logic [ffvt_pkg::PostW-1:0] quot
);
  localparam int RemW = COUNT_BITS + 2;
  localparam int QW   = COUNT_BITS + 17;

  logic [RemW-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [COUNT_BITS:0] den_r, den_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [RemW-1:0]  shifted;

  // Shift in one dividend bit, subtract when it fits.
  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r[RemW-2:0], q_r[QW-1]};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = {pos, 17'd0};
      den_nxt  = total;
      cnt_nxt  = 6'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= RemW'(den_r)) begin
        rem_nxt = shifted - RemW'(den_r);
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  // Dividend was p << 17 so drop the extra bit; p <= t keeps quotient <= 1.0.
  assign busy = busy_r;
  assign quot = (den_r == '0) ? '0 : q_r[ffvt_pkg::PostW:1];
endmodule

// ===== sv/ffvt_lane.sv =====
// One fern: leaf stores, counter update and posterior divider.
`timescale 1ns / 1ps
module ffvt_lane #(
  parameter int LEAVES_PER_FERN = 8192,
  parameter int COUNT_BITS      = 16,
  parameter int AddrW           = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ffvt_pkg::lane_ctl_t        ctl,
  input  logic [AddrW-1:0]           addr,
  output logic [ffvt_pkg::PostW-1:0] post,
  output logic                       busy
);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [COUNT_BITS-1:0]      pos_mem [LEAVES_PER_FERN];
  logic [COUNT_BITS-1:0]      neg_mem [LEAVES_PER_FERN];
  logic [ffvt_pkg::PostW-1:0] post_mem [LEAVES_PER_FERN];

  logic [COUNT_BITS-1:0] pos_rd_r, neg_rd_r, pos_new_r, neg_new_r;
  logic [ffvt_pkg::PostW-1:0] post_rd_r;
  logic [COUNT_BITS-1:0] pos_new_nxt, neg_new_nxt;
  logic [ffvt_pkg::PostW-1:0] quot;

  // Read the addressed leaf; write back counts and posterior, or clear.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      pos_rd_r  <= pos_mem[addr];
      neg_rd_r  <= neg_mem[addr];
      post_rd_r <= post_mem[addr];
    end
    if (ctl.clear_en) begin
      pos_mem[addr]  <= '0;
      neg_mem[addr]  <= '0;
      post_mem[addr] <= '0;
    end else if (ctl.wr_en) begin
      pos_mem[addr]  <= pos_new_r;
      neg_mem[addr]  <= neg_new_r;
      post_mem[addr] <= (pos_new_r == '0) ? '0 : quot;
    end
  end

  // Bump the chosen counter, saturating.
  always_comb begin
    pos_new_nxt = pos_rd_r;
    neg_new_nxt = neg_rd_r;
    if (ctl.positive) begin
      if (pos_rd_r != CntMax) pos_new_nxt = pos_rd_r + 1'b1;
    end else begin
      if (neg_rd_r != CntMax) neg_new_nxt = neg_rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      pos_new_r <= pos_new_nxt;
      neg_new_r <= neg_new_nxt;
    end
  end

  ffvt_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .pos   (pos_new_nxt),
    .total ({1'b0, pos_new_nxt} + {1'b0, neg_new_nxt}),
    .busy  (busy),
    .quot  (quot)
  );

  assign post = post_rd_r;
endmodule

// ===== sv/fern_forest_vote_train_top.sv =====
// Top level: config registers, sequencer, fern lanes and vote merge.
`timescale 1ns / 1ps
// Random-fern posterior engine. Each in_ beat carries a request type on in_tuser
// and one 13-bit leaf code per fern on in_tdata; one out_ beat returns the vote
// (sum of addressed leaf posteriors, Q4.16), whether the tables were trained,
// and the batch mark. All ferns run as parallel lanes, each with its own leaf
// memory and divider. After accept, a classify, or a training sample judged
// correctly, passes the read, sum and train states to the result; a training
// update adds the bit-serial posterior division and the write-back. The next
// beat is accepted no earlier than the cycle after the result beat. After reset
// the stores are cleared one leaf per cycle in every lane at once, while
// in_tready stays low.
module fern_forest_vote_train_top #(
  parameter int NUM_FERNS       = 10,
  parameter int LEAVES_PER_FERN = 8192,
  parameter int COUNT_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // code_fern0[12:0] .. code_fern9[129:117], zero pad
  input  logic [135:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // vote_sum[19:0], did_update[20], zero pad
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AddrW  = (LEAVES_PER_FERN > 1) ? $clog2(LEAVES_PER_FERN) : 1;
  localparam int Lanes  = (NUM_FERNS < ffvt_pkg::InFerns) ? NUM_FERNS : ffvt_pkg::InFerns;
  localparam logic [3:0] LanesC = 4'(Lanes);
  localparam logic [AddrW-1:0] LastLeaf = AddrW'(LEAVES_PER_FERN - 1);

  // Configuration registers.
  logic [3:0]  ferns_used_r;
  logic [15:0] pos_thresh_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ferns_used_r <= ffvt_pkg::FernsUsedReset;
      pos_thresh_r <= ffvt_pkg::PosThreshReset;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
      if (cfg_paddr[2] == ffvt_pkg::REG_FERNS_USED) ferns_used_r <= cfg_pwdata[3:0];
      else pos_thresh_r <= cfg_pwdata[15:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == ffvt_pkg::REG_FERNS_USED) cfg_prdata[3:0] = ferns_used_r;
    else cfg_prdata[15:0] = pos_thresh_r;
  end

  // Effective fern count.
  logic [3:0] n_eff;
  always_comb begin
    n_eff = ferns_used_r;
    if (n_eff == 4'd0) n_eff = 4'd1;
    if (n_eff > LanesC) n_eff = LanesC;
  end

  // Captured item.
  logic [ffvt_pkg::ReqW-1:0] req_r;
  logic                      last_r;
  logic [AddrW-1:0]          code_r [Lanes];
  logic [3:0]                n_r;

  ffvt_pkg::state_t state_r, state_nxt;
  ffvt_pkg::lane_ctl_t ctl;
  logic [AddrW-1:0] clr_r, clr_nxt;
  logic [ffvt_pkg::PostW-1:0] post [Lanes];
  logic [Lanes-1:0] busy;
  logic [ffvt_pkg::VoteW+1:0] vote_r, vote_nxt;
  logic [ffvt_pkg::VoteW+1:0] pos_lim, neg_lim;
  logic upd_nxt;
  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  // Merge lane posteriors into the vote.
  always_comb begin
    vote_nxt = '0;
    for (int i = 0; i < Lanes; i++) begin
      if (4'(i) < n_r) vote_nxt = vote_nxt + (ffvt_pkg::VoteW+2)'(post[i]);
    end
  end

  assign pos_lim = (ffvt_pkg::VoteW+2)'(pos_thresh_r) * (ffvt_pkg::VoteW+2)'(n_r);
  assign neg_lim = (ffvt_pkg::VoteW+2)'({n_r, 15'd0});

  always_comb begin
    upd_nxt = 1'b0;
    if (req_r == ffvt_pkg::REQ_TRAIN_POS) upd_nxt = vote_r <= pos_lim;
    else if (req_r == ffvt_pkg::REQ_TRAIN_NEG) upd_nxt = vote_r >= neg_lim;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ctl           = '0;
    ctl.positive  = (req_r == ffvt_pkg::REQ_TRAIN_POS);
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    case (state_r)
      ffvt_pkg::ST_CLEAR: begin
        ctl.clear_en = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LastLeaf) state_nxt = ffvt_pkg::ST_IDLE;
      end
      ffvt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ffvt_pkg::ST_READ;
      end
      ffvt_pkg::ST_READ: begin
        ctl.rd_en = 1'b1;
        state_nxt = ffvt_pkg::ST_SUM;
      end
      ffvt_pkg::ST_SUM: state_nxt = ffvt_pkg::ST_TRAIN;
      ffvt_pkg::ST_TRAIN: begin
        if (upd_nxt) begin
          ctl.div_start = 1'b1;
          state_nxt = ffvt_pkg::ST_WRITE;
        end else begin
          state_nxt = ffvt_pkg::ST_OUT;
        end
      end
      ffvt_pkg::ST_WRITE: begin
        if (busy == '0) begin
          ctl.wr_en = 1'b1;
          state_nxt = ffvt_pkg::ST_OUT;
        end
      end
      ffvt_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ffvt_pkg::ST_IDLE;
      end
      default: state_nxt = ffvt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffvt_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Hold item and vote.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_tuser;
      last_r <= in_tlast;
      n_r    <= n_eff;
      for (int i = 0; i < Lanes; i++)
        code_r[i] <= in_tdata[13*i +: AddrW];
    end
    if (state_r == ffvt_pkg::ST_SUM) vote_r <= vote_nxt;
  end

  // Decision is registered the cycle after the vote.
  logic dec_r;
  always_ff @(posedge clk) begin
    if (state_r == ffvt_pkg::ST_TRAIN) dec_r <= upd_nxt;
  end

  // Lanes.
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    ffvt_pkg::lane_ctl_t lctl;
    logic [AddrW-1:0] laddr;
    always_comb begin
      lctl = ctl;
      lctl.div_start = ctl.div_start && (4'(g) < n_r);
      lctl.wr_en     = ctl.wr_en && (4'(g) < n_r);
      laddr = (state_r == ffvt_pkg::ST_CLEAR) ? clr_r : code_r[g];
    end
    ffvt_lane #(
      .LEAVES_PER_FERN(LEAVES_PER_FERN),
      .COUNT_BITS     (COUNT_BITS),
      .AddrW          (AddrW)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lctl),
      .addr  (laddr),
      .post  (post[g]),
      .busy  (busy[g])
    );
  end

  assign out_tdata = {3'd0, dec_r, vote_r[ffvt_pkg::VoteW-1:0]};
  assign out_tlast = last_r;
endmodule
